[hw/rtl/sst_pkg.sv]
// Shared constants and types of the four-pass star stencil.
package sst_pkg;

   // configuration register indexes
   localparam int REG_GRID_COLUMNS = 0;
   localparam int REG_GRID_ROWS    = 1;

   localparam int CSR_INDEX_BITS    = 8;
   localparam int CSR_DATA_BITS     = 16;
   localparam int GRID_COLUMNS_BITS = 11;
   localparam int GRID_ROWS_BITS    = 16;
   localparam int ROW_OUT_BITS      = 16;
   localparam int COL_OUT_BITS      = 10;

   localparam int MIN_GRID_SIZE = 5;
   localparam int RESET_COLUMNS = 1024;
   localparam int RESET_ROWS    = 1024;

   // stencil weights
   localparam int TAP_N2 = 7;
   localparam int TAP_N1 = 5;
   localparam int TAP_W2 = 9;
   localparam int TAP_W1 = 12;
   localparam int TAP_C  = 15;
   localparam int DIVISOR = 118;

   // the weights add up to 81, so the exact sum needs seven more bits
   localparam int SUM_GROWTH = 7;
   localparam int REM_BITS   = 7;
   localparam int DIV_STEP   = 8;
   localparam int PASS_FIXED_STAGES = 5;

   typedef struct packed {
      logic       act;
      logic       keep;
      logic [1:0] slot;
   } pass_ctl_type;

   function automatic int pass_latency(input int sample_bits);
      return (sample_bits + SUM_GROWTH + DIV_STEP - 1) / DIV_STEP + PASS_FIXED_STAGES;
   endfunction

endpackage

[hw/rtl/sst_if.sv]
// Channel interfaces for requests, results and register writes.
interface sst_req_if #(parameter int SAMPLE_BITS = 32);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          padding;
   modport source (output valid, sample, padding, input ready);
   modport sink (input valid, sample, padding, output ready);
endinterface

interface sst_rsp_if #(parameter int SAMPLE_BITS = 32);
   logic                              valid;
   logic                              ready;
   logic signed [SAMPLE_BITS-1:0]     result_value;
   logic [sst_pkg::ROW_OUT_BITS-1:0]  result_row;
   logic [sst_pkg::COL_OUT_BITS-1:0]  result_column;
   logic                              last_of_frame;
   modport source (output valid, result_value, result_row, result_column, last_of_frame,
                   input ready);
   modport sink (input valid, result_value, result_row, result_column, last_of_frame,
                 output ready);
endinterface

interface sst_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sst_pkg::CSR_INDEX_BITS-1:0] index;
   logic [sst_pkg::CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/sst_pass.sv]
// One stencil pass: line memory, sliding window, exact sum and divide by 118.
module sst_pass #(
   parameter int MAX_COLUMNS = 1024,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [SAMPLE_BITS-1:0]          in_value,
   input  sst_pkg::pass_ctl_type                  in_ctl,
   input  logic [$clog2(MAX_COLUMNS)-1:0]         in_col,
   output logic                                   out_valid,
   output logic signed [SAMPLE_BITS-1:0]          out_value
);
   import sst_pkg::*;

   localparam int COL_BITS   = $clog2(MAX_COLUMNS);
   localparam int SUM_BITS   = SAMPLE_BITS + SUM_GROWTH;
   localparam int DIV_STAGES = (SUM_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_BITS   = DIV_STAGES * DIV_STEP;

   localparam logic signed [SUM_BITS-1:0] K_N2 = SUM_BITS'(TAP_N2);
   localparam logic signed [SUM_BITS-1:0] K_N1 = SUM_BITS'(TAP_N1);
   localparam logic signed [SUM_BITS-1:0] K_W2 = SUM_BITS'(TAP_W2);
   localparam logic signed [SUM_BITS-1:0] K_W1 = SUM_BITS'(TAP_W1);
   localparam logic signed [SUM_BITS-1:0] K_C  = SUM_BITS'(TAP_C);
   localparam logic [REM_BITS:0] K_DIV = (REM_BITS + 1)'(DIVISOR);

   typedef logic [3:0][SAMPLE_BITS-1:0] line_word_type;

   typedef struct packed {
      logic                valid;
      logic                keep;
      logic                neg;
      logic [REM_BITS-1:0] rem;
      logic [DIV_BITS-1:0] quo;
   } div_type;

   line_word_type line_mem [MAX_COLUMNS];
   line_word_type rd_ff;
   line_word_type wr_word;

   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   pass_ctl_type                  s1_ctl_ff;
   logic [COL_BITS-1:0]           s1_col_ff;

   logic signed [SAMPLE_BITS-1:0] win_ff [5];
   logic signed [SUM_BITS-1:0]    vert_ff [3];

   logic                          s2_valid_ff;
   logic                          s2_keep_ff;
   logic                          s3_valid_ff;
   logic                          s3_keep_ff;
   logic signed [SUM_BITS-1:0]    s3_sum_ff;

   div_type div_ff [DIV_STAGES+1];
   div_type div_in [DIV_STAGES+1];

   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_value_ff;

   logic [1:0]                    idx_up1;
   logic [1:0]                    idx_mid;
   logic [1:0]                    idx_dn1;
   logic signed [SUM_BITS-1:0]    vq;
   logic signed [SUM_BITS-1:0]    total;
   logic signed [SUM_BITS-1:0]    mag;
   logic [SAMPLE_BITS-1:0]        quo;
   logic signed [SAMPLE_BITS-1:0] res;

   // line memory: read at the column on entry, write the updated word back from the stage-1 registers
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= line_mem[in_col];
         if (s1_valid_ff && s1_ctl_ff.act) begin
            line_mem[s1_col_ff] <= wr_word;
         end
      end
   end

   always_comb begin
      idx_up1 = s1_ctl_ff.slot + 2'd1;
      idx_mid = s1_ctl_ff.slot + 2'd2;
      idx_dn1 = s1_ctl_ff.slot + 2'd3;
      vq = K_N2 * (SUM_BITS'(signed'(rd_ff[s1_ctl_ff.slot])) + SUM_BITS'(s1_x_ff))
         + K_N1 * (SUM_BITS'(signed'(rd_ff[idx_up1])) + SUM_BITS'(signed'(rd_ff[idx_dn1])));
      wr_word = rd_ff;
      wr_word[s1_ctl_ff.slot] = s1_x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 5; k++) begin
            win_ff[k] <= '0;
         end
         for (int k = 0; k < 3; k++) begin
            vert_ff[k] <= '0;
         end
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_ff[k] <= '0;
         end
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         out_valid_ff <= div_ff[DIV_STAGES].valid;
         // shift the window only on steps that belong to the grid
         if (s1_valid_ff && s1_ctl_ff.act) begin
            for (int k = 4; k > 0; k--) begin
               win_ff[k] <= win_ff[k-1];
            end
            win_ff[0] <= rd_ff[idx_mid];
            vert_ff[2] <= vert_ff[1];
            vert_ff[1] <= vert_ff[0];
            vert_ff[0] <= vq;
         end
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff <= in_value;
         s1_ctl_ff <= in_ctl;
         s1_col_ff <= in_col;
         s2_keep_ff <= s1_ctl_ff.keep;
         s3_keep_ff <= s2_keep_ff;
         s3_sum_ff <= total;
         out_value_ff <= res;
      end
   end

   always_comb begin
      total = vert_ff[2]
            + K_W2 * (SUM_BITS'(win_ff[4]) + SUM_BITS'(win_ff[0]))
            + K_W1 * (SUM_BITS'(win_ff[3]) + SUM_BITS'(win_ff[1]))
            + K_C * SUM_BITS'(win_ff[2]);
   end

   // long division of the magnitude by 118, eight bits per stage
   always_comb begin
      logic [REM_BITS:0] t;
      logic [REM_BITS-1:0] rem;
      logic [DIV_BITS-1:0] q;
      logic bit_q;
      mag = s3_sum_ff[SUM_BITS-1] ? -s3_sum_ff : s3_sum_ff;
      div_in[0].valid = s3_valid_ff;
      div_in[0].keep  = s3_keep_ff;
      div_in[0].neg   = s3_sum_ff[SUM_BITS-1];
      div_in[0].rem   = '0;
      div_in[0].quo   = DIV_BITS'(unsigned'(mag));
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem = div_ff[k].rem;
         q = div_ff[k].quo;
         for (int j = 0; j < DIV_STEP; j++) begin
            t = {rem, q[DIV_BITS-1]};
            bit_q = (t >= K_DIV);
            rem = bit_q ? REM_BITS'(t - K_DIV) : t[REM_BITS-1:0];
            q = {q[DIV_BITS-2:0], bit_q};
         end
         div_in[k+1].valid = div_ff[k].valid;
         div_in[k+1].keep  = div_ff[k].keep;
         div_in[k+1].neg   = div_ff[k].neg;
         div_in[k+1].rem   = rem;
         div_in[k+1].quo   = q;
      end
   end

   always_comb begin
      quo = div_ff[DIV_STAGES].quo[SAMPLE_BITS-1:0];
      if (!div_ff[DIV_STAGES].keep) begin
         res = '0;
      end else if (div_ff[DIV_STAGES].neg) begin
         res = -signed'(quo);
      end else begin
         res = signed'(quo);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

endmodule

[hw/rtl/star_stencil_2d_radius2_four_pass.sv]
// Top level of the four-pass radius-2 star stencil over a raster grid stream.
//
// Requests carry one grid sample (signed Q16.16) each, in raster order, and a
// padding bit. The first rows*columns requests of a frame are the grid; after
// them the sender supplies PASS_COUNT*(2*columns+2) padding requests so the
// delayed results flush out. Each request yields at most one result: the final
// pass value of one cell with its row, column and an end-of-frame flag.
// One request is taken per clock while the result receiver does not stall.
// A request enters the pipeline at once; each pass does one line-memory
// read/write and one eight-bit-per-stage divide by 118. Registers: index 0
// sets columns, index 1 sets rows; a write restarts the frame position and
// must be made only while the block is idle, which the block does not enforce.
// Reset clears the pipeline and the frame position; line memories keep their
// contents, which are always rewritten before a result depends on them.
// When the result receiver stalls, the whole pipeline holds and request ready
// drops in the same cycle; nothing is lost or repeated.
module star_stencil_2d_radius2_four_pass #(
   parameter int MAX_COLUMNS = 1024,
   parameter int PASS_COUNT  = 4,
   parameter int SAMPLE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   sst_req_if.sink    req_chan,
   sst_rsp_if.source  rsp_chan,
   sst_csr_if.sink    csr_chan
);
   import sst_pkg::*;

   localparam int COL_BITS     = $clog2(MAX_COLUMNS);
   localparam int COL_CNT_BITS = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_CNT_BITS = $clog2(65536 + 2 * PASS_COUNT + 2);
   localparam int PASS_LAT     = pass_latency(SAMPLE_BITS);
   localparam int DLY          = PASS_COUNT * PASS_LAT;
   localparam int COLS_RESET   = (RESET_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RESET_COLUMNS;

   typedef struct packed {
      logic                                    have;
      logic                                    last;
      logic [ROW_OUT_BITS-1:0]                 row;
      logic [COL_OUT_BITS-1:0]                 col;
      pass_ctl_type [PASS_COUNT-1:0]           ctl;
      logic [PASS_COUNT-1:0][COL_BITS-1:0]     pcol;
   } meta_type;

   logic [COL_CNT_BITS-1:0]   cols_used_ff;
   logic [GRID_ROWS_BITS-1:0] rows_used_ff;
   logic [ROW_CNT_BITS-1:0]   row_ff [PASS_COUNT+1];
   logic [ROW_CNT_BITS-1:0]   row_in [PASS_COUNT+1];
   logic [COL_BITS-1:0]       col_ff [PASS_COUNT+1];
   logic [COL_BITS-1:0]       col_in [PASS_COUNT+1];
   logic [PASS_COUNT:1]       run_ff;
   logic [PASS_COUNT:1]       run_in;
   logic [PASS_COUNT:0]       go;

   meta_type meta_in;
   meta_type d_ff [1:DLY];

   logic                          en;
   logic                          accept;
   logic                          csr_write;
   logic                          size_write;
   logic [COL_BITS-1:0]           last_col;
   logic [ROW_CNT_BITS-1:0]       last_row;
   logic [ROW_CNT_BITS-1:0]       rows_ext;
   logic signed [SAMPLE_BITS-1:0] x0;
   logic [GRID_COLUMNS_BITS-1:0]  gc;
   logic [GRID_ROWS_BITS-1:0]     gr;

   logic                          pv [PASS_COUNT];
   logic signed [SAMPLE_BITS-1:0] pval [PASS_COUNT];

   assign en       = !rsp_chan.valid || rsp_chan.ready;
   assign accept   = req_chan.valid && en;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;
   assign csr_write  = csr_chan.valid;
   assign size_write = csr_write && (csr_chan.index == CSR_INDEX_BITS'(REG_GRID_COLUMNS) ||
                                     csr_chan.index == CSR_INDEX_BITS'(REG_GRID_ROWS));
   assign gc = csr_chan.data[GRID_COLUMNS_BITS-1:0];
   assign gr = csr_chan.data[GRID_ROWS_BITS-1:0];

   // clamp sizes on write
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_used_ff <= COL_CNT_BITS'(COLS_RESET);
         rows_used_ff <= GRID_ROWS_BITS'(RESET_ROWS);
      end else if (csr_write) begin
         if (csr_chan.index == CSR_INDEX_BITS'(REG_GRID_COLUMNS)) begin
            if (gc < GRID_COLUMNS_BITS'(MIN_GRID_SIZE)) begin
               cols_used_ff <= COL_CNT_BITS'(MIN_GRID_SIZE);
            end else if (int'(gc) > MAX_COLUMNS) begin
               cols_used_ff <= COL_CNT_BITS'(MAX_COLUMNS);
            end else begin
               cols_used_ff <= COL_CNT_BITS'(gc);
            end
         end else if (csr_chan.index == CSR_INDEX_BITS'(REG_GRID_ROWS)) begin
            if (gr < GRID_ROWS_BITS'(MIN_GRID_SIZE)) begin
               rows_used_ff <= GRID_ROWS_BITS'(MIN_GRID_SIZE);
            end else begin
               rows_used_ff <= gr;
            end
         end
      end
   end

   assign last_col = COL_BITS'(cols_used_ff - COL_CNT_BITS'(1));
   assign last_row = ROW_CNT_BITS'(rows_used_ff - GRID_ROWS_BITS'(1));
   assign rows_ext = ROW_CNT_BITS'(rows_used_ff);

   // frame position of every pass and of the result, decided at entry
   always_comb begin
      go[0] = 1'b1;
      for (int p = 0; p < PASS_COUNT; p++) begin
         go[p+1] = run_ff[p+1] ||
                   (go[p] && row_ff[p] == ROW_CNT_BITS'(2) && col_ff[p] == COL_BITS'(2));
      end
      meta_in = '0;
      for (int p = 0; p < PASS_COUNT; p++) begin
         meta_in.ctl[p].act  = go[p] && (row_ff[p] < rows_ext);
         meta_in.ctl[p].keep = go[p] && (row_ff[p] < rows_ext) &&
                               row_ff[p] >= ROW_CNT_BITS'(4) && col_ff[p] >= COL_BITS'(4);
         meta_in.ctl[p].slot = row_ff[p][1:0];
         meta_in.pcol[p]     = col_ff[p];
      end
      meta_in.have = accept && go[PASS_COUNT];
      meta_in.last = accept && go[PASS_COUNT] && row_ff[PASS_COUNT] == last_row &&
                     col_ff[PASS_COUNT] == last_col;
      meta_in.row  = ROW_OUT_BITS'(row_ff[PASS_COUNT]);
      meta_in.col  = COL_OUT_BITS'(col_ff[PASS_COUNT]);
   end

   always_comb begin
      for (int p = 0; p <= PASS_COUNT; p++) begin
         row_in[p] = row_ff[p];
         col_in[p] = col_ff[p];
      end
      run_in = run_ff;
      if (size_write || meta_in.last) begin
         for (int p = 0; p <= PASS_COUNT; p++) begin
            row_in[p] = '0;
            col_in[p] = '0;
         end
         run_in = '0;
      end else if (accept) begin
         for (int p = 0; p <= PASS_COUNT; p++) begin
            if (go[p]) begin
               if (col_ff[p] == last_col) begin
                  col_in[p] = '0;
                  row_in[p] = row_ff[p] + ROW_CNT_BITS'(1);
               end else begin
                  col_in[p] = col_ff[p] + COL_BITS'(1);
               end
            end
         end
         run_in = go[PASS_COUNT:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p <= PASS_COUNT; p++) begin
            row_ff[p] <= '0;
            col_ff[p] <= '0;
         end
         run_ff <= '0;
      end else begin
         for (int p = 0; p <= PASS_COUNT; p++) begin
            row_ff[p] <= row_in[p];
            col_ff[p] <= col_in[p];
         end
         run_ff <= run_in;
      end
   end

   // per-request frame data travels beside the passes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= DLY; k++) begin
            d_ff[k] <= '0;
         end
      end else if (en) begin
         d_ff[1] <= meta_in;
         for (int k = 2; k <= DLY; k++) begin
            d_ff[k] <= d_ff[k-1];
         end
      end
   end

   // grid requests take the sample, padding and flush requests take zero
   assign x0 = (meta_in.ctl[0].act && !req_chan.padding) ? req_chan.sample : '0;

   for (genvar p = 0; p < PASS_COUNT; p++) begin : g_pass
      if (p == 0) begin : g_first
         sst_pass #(
            .MAX_COLUMNS (MAX_COLUMNS),
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_pass (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (accept),
            .in_value  (x0),
            .in_ctl    (meta_in.ctl[0]),
            .in_col    (meta_in.pcol[0]),
            .out_valid (pv[0]),
            .out_value (pval[0])
         );
      end else begin : g_next
         sst_pass #(
            .MAX_COLUMNS (MAX_COLUMNS),
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_pass (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (pv[p-1]),
            .in_value  (pval[p-1]),
            .in_ctl    (d_ff[p*PASS_LAT].ctl[p]),
            .in_col    (d_ff[p*PASS_LAT].pcol[p]),
            .out_valid (pv[p]),
            .out_value (pval[p])
         );
      end
   end

   assign rsp_chan.valid         = pv[PASS_COUNT-1] && d_ff[DLY].have;
   assign rsp_chan.result_value  = pval[PASS_COUNT-1];
   assign rsp_chan.result_row    = d_ff[DLY].row;
   assign rsp_chan.result_column = d_ff[DLY].col;
   assign rsp_chan.last_of_frame = d_ff[DLY].last;

`ifndef SYNTHESIS
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      COL_CNT_BITS'(col_ff[0]) < cols_used_ff)
      else $error("input column beyond grid width");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      meta_in.last |=> row_ff[0] == '0 && col_ff[0] == '0 && run_ff == '0)
      else $error("frame position not restarted after last cell");

   a_pass_order: assert property (@(posedge clock) disable iff (reset)
      ((run_ff >> 1) & ~run_ff) == '0)
      else $error("later pass started before earlier pass");

   a_last_column: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_of_frame |->
         rsp_chan.result_column == COL_OUT_BITS'(cols_used_ff - COL_CNT_BITS'(1)))
      else $error("end of frame flagged off the last column");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.result_row < rows_used_ff)
      else $error("result row beyond grid height");
`endif

endmodule
